// File: rtl/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// shared constants for the triangle face normal pipeline
// ----------------------------------------------------------------------------
package tfn_pkg;

   // default field widths
   localparam int INDEX_BITS_DEF    = 16;
   localparam int POSITION_BITS_DEF = 24;
   localparam int NORMAL_BITS_DEF   = 16;

   // normalized magnitude length ahead of quantization
   localparam int UNIT_MAG_BITS = 30;

   // chunk size of the leading-one search
   localparam int CHUNK_BITS = 8;

endpackage

// File: rtl/tfn_cross.sv
// ----------------------------------------------------------------------------
// tfn_cross
// edge vectors, exact cross product, sign and magnitude split (4 stages)
// ----------------------------------------------------------------------------
module tfn_cross import tfn_pkg::*; #(
   parameter int INDEX_BITS    = INDEX_BITS_DEF,
   parameter int POSITION_BITS = POSITION_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic [3*INDEX_BITS-1:0]                in_idx,
   input  logic [2:0][POSITION_BITS-1:0]          in_p0,
   input  logic [2:0][POSITION_BITS-1:0]          in_p1,
   input  logic [2:0][POSITION_BITS-1:0]          in_p2,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic [3*INDEX_BITS-1:0]                out_idx,
   output logic [2:0][2*POSITION_BITS+1:0]        out_mag,
   output logic [2:0]                             out_neg
);

   localparam int EW = POSITION_BITS + 1;
   localparam int CW = 2 * POSITION_BITS + 2;
   localparam int NS = 4;

   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;
   logic [NS:0]   en;

   logic signed [EW-1:0] ea_ff [3];
   logic signed [EW-1:0] eb_ff [3];
   logic signed [CW-1:0] pr_ff [6];
   logic signed [CW-1:0] c_ff  [3];
   logic [2:0][CW-1:0]   mag_ff;
   logic [2:0]           neg_ff;
   logic [3*INDEX_BITS-1:0] idx_ff [NS];

   // stage moves when empty or when the next one moves
   assign en[NS] = out_ready;
   for (genvar s = 0; s < NS; s++) begin : g_en
      assign en[s] = ~valid_ff[s] | en[s+1];
   end
   assign valid_in = {valid_ff[NS-2:0], in_valid};
   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < NS; s++) begin
            if (en[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int i = 0; i < 3; i++) begin
            ea_ff[i] <= {in_p1[i][POSITION_BITS-1], in_p1[i]}
                      - {in_p0[i][POSITION_BITS-1], in_p0[i]};
            eb_ff[i] <= {in_p2[i][POSITION_BITS-1], in_p2[i]}
                      - {in_p0[i][POSITION_BITS-1], in_p0[i]};
         end
         idx_ff[0] <= in_idx;
      end
      if (en[1]) begin
         pr_ff[0]  <= ea_ff[1] * eb_ff[2];
         pr_ff[1]  <= ea_ff[2] * eb_ff[1];
         pr_ff[2]  <= ea_ff[2] * eb_ff[0];
         pr_ff[3]  <= ea_ff[0] * eb_ff[2];
         pr_ff[4]  <= ea_ff[0] * eb_ff[1];
         pr_ff[5]  <= ea_ff[1] * eb_ff[0];
         idx_ff[1] <= idx_ff[0];
      end
      if (en[2]) begin
         for (int i = 0; i < 3; i++) begin
            c_ff[i] <= pr_ff[2*i] - pr_ff[2*i+1];
         end
         idx_ff[2] <= idx_ff[1];
      end
      if (en[3]) begin
         for (int i = 0; i < 3; i++) begin
            neg_ff[i] <= c_ff[i][CW-1];
            mag_ff[i] <= c_ff[i][CW-1] ? CW'(-c_ff[i]) : CW'(c_ff[i]);
         end
         idx_ff[3] <= idx_ff[2];
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign out_idx   = idx_ff[NS-1];
   assign out_mag   = mag_ff;
   assign out_neg   = neg_ff;

endmodule

// File: rtl/tfn_norm.sv
// ----------------------------------------------------------------------------
// tfn_norm
// leading-one search, shift to fixed length, squares and their sum (5 stages)
// ----------------------------------------------------------------------------
module tfn_norm import tfn_pkg::*; #(
   parameter int INDEX_BITS    = INDEX_BITS_DEF,
   parameter int POSITION_BITS = POSITION_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic [3*INDEX_BITS-1:0]                in_idx,
   input  logic [2:0][2*POSITION_BITS+1:0]        in_mag,
   input  logic [2:0]                             in_neg,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic [3*INDEX_BITS-1:0]                out_idx,
   output logic [2:0][2*UNIT_MAG_BITS-1:0]        out_sq,
   output logic [2*UNIT_MAG_BITS+1:0]             out_sum,
   output logic [2:0]                             out_neg,
   output logic                                   out_degen
);

   localparam int CW  = 2 * POSITION_BITS + 2;
   localparam int MB  = UNIT_MAG_BITS;
   localparam int SW  = 2 * MB + 2;
   localparam int NCH = (CW + CHUNK_BITS - 1) / CHUNK_BITS;
   localparam int PW  = NCH * CHUNK_BITS;
   localparam int CLW = $clog2(CHUNK_BITS + 1);
   localparam int LW  = $clog2(PW + 1);
   localparam int NS  = 5;

   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;
   logic [NS:0]   en;

   logic [PW-1:0]           or_word;
   logic [CLW-1:0]          clen_in [NCH];
   logic [CLW-1:0]          clen_ff [NCH];
   logic [LW-1:0]           len_in;
   logic [LW-1:0]           len_ff;
   logic [2:0][CW-1:0]      mag1_ff;
   logic [2:0][CW-1:0]      mag2_ff;
   logic [MB-1:0]           v_ff  [3];
   logic [2:0][2*MB-1:0]    sq4_ff;
   logic [2:0][2*MB-1:0]    sq5_ff;
   logic [SW-1:0]           sum_ff;
   // degenerate flag exists from the shift stage on
   logic [NS-1:2]           dg_ff;
   logic [2:0]              neg_ff [NS];
   logic [3*INDEX_BITS-1:0] idx_ff [NS];

   assign en[NS] = out_ready;
   for (genvar s = 0; s < NS; s++) begin : g_en
      assign en[s] = ~valid_ff[s] | en[s+1];
   end
   assign valid_in = {valid_ff[NS-2:0], in_valid};
   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < NS; s++) begin
            if (en[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
      end
   end

   // bit length of each chunk of the or of all magnitudes
   assign or_word = PW'(in_mag[0] | in_mag[1] | in_mag[2]);
   always_comb begin
      for (int c = 0; c < NCH; c++) begin
         clen_in[c] = '0;
         for (int j = 0; j < CHUNK_BITS; j++) begin
            if (or_word[c*CHUNK_BITS+j]) begin
               clen_in[c] = CLW'(j + 1);
            end
         end
      end
   end

   // highest nonzero chunk gives the overall length
   always_comb begin
      len_in = '0;
      for (int c = 0; c < NCH; c++) begin
         if (clen_ff[c] != '0) begin
            len_in = LW'(c * CHUNK_BITS) + LW'(clen_ff[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         clen_ff   <= clen_in;
         mag1_ff   <= in_mag;
         neg_ff[0] <= in_neg;
         idx_ff[0] <= in_idx;
      end
      if (en[1]) begin
         len_ff    <= len_in;
         mag2_ff   <= mag1_ff;
         neg_ff[1] <= neg_ff[0];
         idx_ff[1] <= idx_ff[0];
      end
      if (en[2]) begin
         // largest magnitude lands at exactly MB bits
         for (int i = 0; i < 3; i++) begin
            v_ff[i] <= MB'({mag2_ff[i], {MB{1'b0}}} >> len_ff);
         end
         dg_ff[2]  <= (len_ff == '0);
         neg_ff[2] <= neg_ff[1];
         idx_ff[2] <= idx_ff[1];
      end
      if (en[3]) begin
         for (int i = 0; i < 3; i++) begin
            sq4_ff[i] <= (2*MB)'(v_ff[i]) * (2*MB)'(v_ff[i]);
         end
         dg_ff[3]  <= dg_ff[2];
         neg_ff[3] <= neg_ff[2];
         idx_ff[3] <= idx_ff[2];
      end
      if (en[4]) begin
         sum_ff    <= SW'(sq4_ff[0]) + SW'(sq4_ff[1]) + SW'(sq4_ff[2]);
         sq5_ff    <= sq4_ff;
         dg_ff[4]  <= dg_ff[3];
         neg_ff[4] <= neg_ff[3];
         idx_ff[4] <= idx_ff[3];
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign out_idx   = idx_ff[NS-1];
   assign out_sq    = sq5_ff;
   assign out_sum   = sum_ff;
   assign out_neg   = neg_ff[NS-1];
   assign out_degen = dg_ff[NS-1];

endmodule

// File: rtl/tfn_quant.sv
// ----------------------------------------------------------------------------
// tfn_quant
// exact rounded unit component, one result bit per stage, then sign and clamp
// ----------------------------------------------------------------------------
module tfn_quant import tfn_pkg::*; #(
   parameter int INDEX_BITS  = INDEX_BITS_DEF,
   parameter int NORMAL_BITS = NORMAL_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic [3*INDEX_BITS-1:0]                in_idx,
   input  logic [2:0][2*UNIT_MAG_BITS-1:0]        in_sq,
   input  logic [2*UNIT_MAG_BITS+1:0]             in_sum,
   input  logic [2:0]                             in_neg,
   input  logic                                   in_degen,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic [3*INDEX_BITS-1:0]                out_idx,
   output logic [2:0][NORMAL_BITS-1:0]            out_normal,
   output logic                                   out_degen
);

   localparam int F  = NORMAL_BITS - 1;
   localparam int MB = UNIT_MAG_BITS;
   localparam int SW = 2 * MB + 2;
   localparam int RW = 2 * F + 2 * MB + 8;
   localparam int NI = F + 2;        // init stage plus one stage per result bit
   localparam int NS = NI + 1;

   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;
   logic [NS:0]   en;

   // d: residual target minus (2k-1)^2 * s, cr: (2k-1) * s
   logic signed [RW-1:0]    d_ff  [NI][3];
   logic signed [RW-1:0]    cr_ff [NI][3];
   logic [F:0]              k_ff  [NI][3];
   logic [SW-1:0]           s_ff  [NI];
   logic [2:0]              neg_ff [NI];
   logic                    dg_ff  [NI];
   logic [3*INDEX_BITS-1:0] idx_ff [NI];

   logic [2:0][NORMAL_BITS-1:0] nrm_ff;
   logic                        dgo_ff;
   logic [3*INDEX_BITS-1:0]     idxo_ff;

   assign en[NS] = out_ready;
   for (genvar s = 0; s < NS; s++) begin : g_en
      assign en[s] = ~valid_ff[s] | en[s+1];
   end
   assign valid_in = {valid_ff[NS-2:0], in_valid};
   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < NS; s++) begin
            if (en[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
      end
   end

   // init: k = 0, so 2k-1 = -1
   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int i = 0; i < 3; i++) begin
            d_ff[0][i]  <= (RW'(in_sq[i]) << (2*F + 2)) - RW'(in_sum);
            cr_ff[0][i] <= -RW'(in_sum);
            k_ff[0][i]  <= '0;
         end
         s_ff[0]   <= in_sum;
         neg_ff[0] <= in_neg;
         dg_ff[0]  <= in_degen;
         idx_ff[0] <= in_idx;
      end
   end

   for (genvar j = 1; j < NI; j++) begin : g_bit
      localparam int BIT = F - (j - 1);
      logic signed [RW-1:0] t [3];
      logic [2:0]           take;

      for (genvar i = 0; i < 3; i++) begin : g_lane
         assign t[i] = d_ff[j-1][i] - (cr_ff[j-1][i] <<< (BIT + 2))
                     - $signed(RW'(s_ff[j-1]) << (2*BIT + 2));
         // no candidate once k has reached one
         assign take[i] = ~t[i][RW-1] & ~k_ff[j-1][i][F];
      end

      always_ff @(posedge clock) begin
         if (en[j]) begin
            for (int i = 0; i < 3; i++) begin
               d_ff[j][i]  <= take[i] ? t[i] : d_ff[j-1][i];
               cr_ff[j][i] <= take[i]
                            ? cr_ff[j-1][i] + $signed(RW'(s_ff[j-1]) << (BIT + 1))
                            : cr_ff[j-1][i];
               k_ff[j][i]  <= take[i] ? (k_ff[j-1][i] | ((F+1)'(1) << BIT))
                                      : k_ff[j-1][i];
            end
            s_ff[j]   <= s_ff[j-1];
            neg_ff[j] <= neg_ff[j-1];
            dg_ff[j]  <= dg_ff[j-1];
            idx_ff[j] <= idx_ff[j-1];
         end
      end
   end

   // clamp +1.0, apply sign, zero for a degenerate triangle
   always_ff @(posedge clock) begin
      if (en[NS-1]) begin
         for (int i = 0; i < 3; i++) begin
            if (dg_ff[NI-1]) begin
               nrm_ff[i] <= '0;
            end else if (k_ff[NI-1][i][F]) begin
               nrm_ff[i] <= neg_ff[NI-1][i] ? -{1'b0, {F{1'b1}}} : {1'b0, {F{1'b1}}};
            end else begin
               nrm_ff[i] <= neg_ff[NI-1][i] ? -k_ff[NI-1][i] : k_ff[NI-1][i];
            end
         end
         dgo_ff  <= dg_ff[NI-1];
         idxo_ff <= idx_ff[NI-1];
      end
   end

   assign out_valid  = valid_ff[NS-1];
   assign out_idx    = idxo_ff;
   assign out_normal = nrm_ff;
   assign out_degen  = dgo_ff;

endmodule

// File: rtl/triangle_face_normal_core.sv
// throughput: one triangle per cycle while rsp is not stalled, set by the
// fully pipelined datapath (4 cross product stages, 5 normalize stages,
// one stage per normal bit + 2)
// a stalled rsp holds the pipeline; empty stages still fill behind it
// reset clears only the stage valid bits, the datapath registers are not reset
// ----------------------------------------------------------------------------
// triangle_face_normal_core
// unit face normal of a triangle, with its corner indices passed through
// ----------------------------------------------------------------------------
module triangle_face_normal_core import tfn_pkg::*; #(
   parameter int INDEX_BITS    = INDEX_BITS_DEF,
   parameter int POSITION_BITS = POSITION_BITS_DEF,
   parameter int NORMAL_BITS   = NORMAL_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request word: one triangle
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [INDEX_BITS-1:0]           req_first_index,
   input  logic [INDEX_BITS-1:0]           req_second_index,
   input  logic [INDEX_BITS-1:0]           req_third_index,
   input  logic signed [POSITION_BITS-1:0] req_first_x,
   input  logic signed [POSITION_BITS-1:0] req_first_y,
   input  logic signed [POSITION_BITS-1:0] req_first_z,
   input  logic signed [POSITION_BITS-1:0] req_second_x,
   input  logic signed [POSITION_BITS-1:0] req_second_y,
   input  logic signed [POSITION_BITS-1:0] req_second_z,
   input  logic signed [POSITION_BITS-1:0] req_third_x,
   input  logic signed [POSITION_BITS-1:0] req_third_y,
   input  logic signed [POSITION_BITS-1:0] req_third_z,
   // response word: normal and indices
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [INDEX_BITS-1:0]           rsp_out_first_index,
   output logic [INDEX_BITS-1:0]           rsp_out_second_index,
   output logic [INDEX_BITS-1:0]           rsp_out_third_index,
   output logic signed [NORMAL_BITS-1:0]   rsp_normal_x,
   output logic signed [NORMAL_BITS-1:0]   rsp_normal_y,
   output logic signed [NORMAL_BITS-1:0]   rsp_normal_z,
   output logic                            rsp_degenerate
);

   localparam int CW = 2 * POSITION_BITS + 2;
   localparam int MB = UNIT_MAG_BITS;

   // request packing, corner zero in element 0, x in element 0
   logic [3*INDEX_BITS-1:0]          req_idx;
   logic [2:0][POSITION_BITS-1:0]    p0;
   logic [2:0][POSITION_BITS-1:0]    p1;
   logic [2:0][POSITION_BITS-1:0]    p2;

   assign req_idx = {req_third_index, req_second_index, req_first_index};
   assign p0 = {req_first_z,  req_first_y,  req_first_x};
   assign p1 = {req_second_z, req_second_y, req_second_x};
   assign p2 = {req_third_z,  req_third_y,  req_third_x};

   // cross product to normalize
   logic                        cx_valid;
   logic                        cx_ready;
   logic [3*INDEX_BITS-1:0]     cx_idx;
   logic [2:0][CW-1:0]          cx_mag;
   logic [2:0]                  cx_neg;

   // normalize to quantize
   logic                        nm_valid;
   logic                        nm_ready;
   logic [3*INDEX_BITS-1:0]     nm_idx;
   logic [2:0][2*MB-1:0]        nm_sq;
   logic [2*MB+1:0]             nm_sum;
   logic [2:0]                  nm_neg;
   logic                        nm_degen;

   // quantize output register
   logic [3*INDEX_BITS-1:0]     qt_idx;
   logic [2:0][NORMAL_BITS-1:0] qt_normal;

   // exact edges and cross product, magnitudes split from signs
   tfn_cross #(
      .INDEX_BITS    (INDEX_BITS),
      .POSITION_BITS (POSITION_BITS)
   ) u_cross (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_idx    (req_idx),
      .in_p0     (p0),
      .in_p1     (p1),
      .in_p2     (p2),
      .out_valid (cx_valid),
      .out_ready (cx_ready),
      .out_idx   (cx_idx),
      .out_mag   (cx_mag),
      .out_neg   (cx_neg)
   );

   // scale so the largest magnitude is 30 bits, then squares and their sum
   tfn_norm #(
      .INDEX_BITS    (INDEX_BITS),
      .POSITION_BITS (POSITION_BITS)
   ) u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cx_valid),
      .in_ready  (cx_ready),
      .in_idx    (cx_idx),
      .in_mag    (cx_mag),
      .in_neg    (cx_neg),
      .out_valid (nm_valid),
      .out_ready (nm_ready),
      .out_idx   (nm_idx),
      .out_sq    (nm_sq),
      .out_sum   (nm_sum),
      .out_neg   (nm_neg),
      .out_degen (nm_degen)
   );

   // round(m * 2^F / sqrt(s)) by exact compare, ties away from zero
   tfn_quant #(
      .INDEX_BITS  (INDEX_BITS),
      .NORMAL_BITS (NORMAL_BITS)
   ) u_quant (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (nm_valid),
      .in_ready   (nm_ready),
      .in_idx     (nm_idx),
      .in_sq      (nm_sq),
      .in_sum     (nm_sum),
      .in_neg     (nm_neg),
      .in_degen   (nm_degen),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_idx    (qt_idx),
      .out_normal (qt_normal),
      .out_degen  (rsp_degenerate)
   );

   assign rsp_out_first_index  = qt_idx[INDEX_BITS-1:0];
   assign rsp_out_second_index = qt_idx[2*INDEX_BITS-1:INDEX_BITS];
   assign rsp_out_third_index  = qt_idx[3*INDEX_BITS-1:2*INDEX_BITS];
   assign rsp_normal_x         = qt_normal[0];
   assign rsp_normal_y         = qt_normal[1];
   assign rsp_normal_z         = qt_normal[2];

endmodule
